[hdl/assert_macros.svh]
// Assertion macros used by the top level of the payload field extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/apfe_pkg.sv]
// Types and codes shared by the payload field extractor modules.
`default_nettype none

package apfe_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR,
    REQ_APPEND,
    REQ_EXTRACT,
    REQ_NONE
  } req_e;

  typedef enum logic [1:0] {
    FMT_UNSIGNED,
    FMT_SIGNMAG,
    FMT_TEXT,
    FMT_HEX
  } fmt_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BEYOND,
    STAT_FULL
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_ACK,
    ST_VALUE,
    ST_PAD
  } state_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ACK,
    OUT_VALUE,
    OUT_PAD
  } out_sel_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] payload_char;
    logic [9:0] bit_offset;
    logic [8:0] bit_count;
    logic [1:0] out_format;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]        field_value;
    logic signed [31:0] signed_value;
    logic [6:0]         text_char;
    logic               last_flag;
    logic [1:0]         status;
  } out_beat_t;

  typedef struct packed {
    logic     latch;
    logic     decode;
    logic     shift;
    logic     next_chunk;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic beyond;
    logic empty;
    logic chunked;
    logic stop;
    logic more;
    logic pad;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/apfe_ctrl.sv]
// Controller state machine that sequences decode, bit walking and result beats.
`default_nettype none

module apfe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  apfe_pkg::stat_t stat_i,
  output apfe_pkg::cmd_t  cmd_o
);

  apfe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      apfe_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = apfe_pkg::ST_DECODE;
      end
      apfe_pkg::ST_DECODE: begin
        case (stat_i.req)
          apfe_pkg::REQ_CLEAR, apfe_pkg::REQ_APPEND: state_d = apfe_pkg::ST_ACK;
          apfe_pkg::REQ_EXTRACT: begin
            if (stat_i.beyond || stat_i.empty) state_d = apfe_pkg::ST_ACK;
            else state_d = apfe_pkg::ST_SHIFT;
          end
          default: state_d = apfe_pkg::ST_IDLE;
        endcase
      end
      apfe_pkg::ST_SHIFT: begin
        if (stat_i.stop) state_d = apfe_pkg::ST_VALUE;
      end
      apfe_pkg::ST_ACK: begin
        if (stat_i.out_free) state_d = apfe_pkg::ST_IDLE;
      end
      apfe_pkg::ST_VALUE: begin
        if (stat_i.out_free) begin
          if (!stat_i.chunked) state_d = apfe_pkg::ST_IDLE;
          else if (stat_i.more) state_d = apfe_pkg::ST_SHIFT;
          else if (stat_i.pad) state_d = apfe_pkg::ST_PAD;
          else state_d = apfe_pkg::ST_IDLE;
        end
      end
      apfe_pkg::ST_PAD: begin
        if (stat_i.out_free) state_d = apfe_pkg::ST_IDLE;
      end
      default: state_d = apfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.out_sel    = apfe_pkg::OUT_NONE;
    case (state_q)
      apfe_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      apfe_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
      end
      apfe_pkg::ST_SHIFT: begin
        cmd_o.shift = !stat_i.stop;
      end
      apfe_pkg::ST_ACK: begin
        if (stat_i.out_free) cmd_o.out_sel = apfe_pkg::OUT_ACK;
      end
      apfe_pkg::ST_VALUE: begin
        if (stat_i.out_free) begin
          cmd_o.out_sel    = apfe_pkg::OUT_VALUE;
          cmd_o.next_chunk = stat_i.chunked && stat_i.more;
        end
      end
      apfe_pkg::ST_PAD: begin
        if (stat_i.out_free) cmd_o.out_sel = apfe_pkg::OUT_PAD;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/apfe_dpath.sv]
// Datapath with the payload memory, bit walker, field formatter and output register.
`default_nettype none

module apfe_dpath #(
  parameter int MAX_CHARS      = 128,
  parameter int MAX_FIELD_BITS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apfe_pkg::in_beat_t  in_data_i,
  input  apfe_pkg::cmd_t      cmd_i,
  output apfe_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apfe_pkg::out_beat_t out_data_o
);

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LW = $clog2(MAX_CHARS + 1);

  // Multiplying by 683 and dropping 12 bits is an exact divide by six for 10-bit offsets.
  localparam logic [19:0] RECIP_SIX = 20'd683;

  apfe_pkg::req_e    req_q;
  apfe_pkg::fmt_e    fmt_q;
  logic [7:0]        char_q;
  logic [9:0]        off_q;
  logic [8:0]        cnt_q;
  logic [8:0]        cnt_clamped;

  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     sidx_q, sidx_d;
  logic [2:0]        bpos_q, bpos_d;
  logic [8:0]        rem_q, rem_d;
  logic [2:0]        kcnt_q, kcnt_d;
  logic              nodd_q, nodd_d;
  logic [63:0]       acc_q, acc_d;
  apfe_pkg::status_e ack_q, ack_d;

  logic [5:0]        mem_q [MAX_CHARS];
  logic [5:0]        rdata_q;
  logic              wr_en;
  logic [5:0]        dearm;

  logic [19:0]       q_prod;
  logic [7:0]        sym_q;
  logic [9:0]        sym_base;
  logic [2:0]        sym_bit;
  logic              full;
  logic              bit_ok;
  logic              cur_bit;
  logic              chunked;
  logic [2:0]        chunk_len;
  logic [8:0]        rem_next;
  logic              more;
  logic              pad;

  logic [4:0]        sb_idx;
  logic [31:0]       sm_mask;
  logic [31:0]       sm_mag;
  logic              sm_ok;
  logic [31:0]       smag;
  logic [6:0]        text_conv;

  logic                out_valid_q;
  apfe_pkg::out_beat_t out_q, out_d;
  logic                out_free;

  assign cnt_clamped = (32'(in_data_i.bit_count) > 32'(MAX_FIELD_BITS)) ?
                       9'(MAX_FIELD_BITS) : in_data_i.bit_count;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= apfe_pkg::req_e'(in_data_i.req_type);
      fmt_q  <= apfe_pkg::fmt_e'(in_data_i.out_format);
      char_q <= in_data_i.payload_char;
      off_q  <= in_data_i.bit_offset;
      cnt_q  <= cnt_clamped;
    end
  end

  assign q_prod   = 20'(off_q) * RECIP_SIX;
  assign sym_q    = q_prod[19:12];
  assign sym_base = 10'(sym_q) * 10'd6;
  assign sym_bit  = 3'(off_q - sym_base);

  assign full      = (len_q == LW'(MAX_CHARS));
  assign bit_ok    = (sidx_q < len_q);
  assign cur_bit   = rdata_q[3'd5 - bpos_q];
  assign chunked   = (fmt_q == apfe_pkg::FMT_TEXT) || (fmt_q == apfe_pkg::FMT_HEX);
  assign chunk_len = (fmt_q == apfe_pkg::FMT_TEXT) ? 3'd6 : 3'd4;
  assign rem_next  = (rem_q > 9'(chunk_len)) ? (rem_q - 9'(chunk_len)) : 9'd0;
  assign more      = (rem_next != 9'd0) && bit_ok;
  assign pad       = !more && (fmt_q == apfe_pkg::FMT_HEX) && !nodd_q;

  assign dearm = ((char_q >= 8'd48) && (char_q <= 8'd87)) ? 6'(char_q - 8'd48)
                                                          : 6'(char_q - 8'd56);
  assign wr_en = cmd_i.decode && (req_q == apfe_pkg::REQ_APPEND) && !full;

  always_comb begin
    len_d  = len_q;
    sidx_d = sidx_q;
    bpos_d = bpos_q;
    rem_d  = rem_q;
    kcnt_d = kcnt_q;
    nodd_d = nodd_q;
    acc_d  = acc_q;
    ack_d  = ack_q;
    if (cmd_i.decode) begin
      case (req_q)
        apfe_pkg::REQ_CLEAR: begin
          len_d = '0;
          ack_d = apfe_pkg::STAT_OK;
        end
        apfe_pkg::REQ_APPEND: begin
          if (full) begin
            ack_d = apfe_pkg::STAT_FULL;
          end else begin
            len_d = len_q + LW'(1);
            ack_d = apfe_pkg::STAT_OK;
          end
        end
        apfe_pkg::REQ_EXTRACT: begin
          ack_d  = stat_o.beyond ? apfe_pkg::STAT_BEYOND : apfe_pkg::STAT_OK;
          sidx_d = LW'(sym_q);
          bpos_d = sym_bit;
          rem_d  = cnt_q;
          kcnt_d = chunk_len;
          nodd_d = 1'b0;
          acc_d  = '0;
        end
        default: begin
          ack_d = ack_q;
        end
      endcase
    end
    if (cmd_i.shift) begin
      acc_d = {acc_q[62:0], cur_bit};
      if (chunked) kcnt_d = kcnt_q - 3'd1;
      else rem_d = rem_q - 9'd1;
      if (bpos_q == 3'd5) begin
        bpos_d = 3'd0;
        sidx_d = sidx_q + LW'(1);
      end else begin
        bpos_d = bpos_q + 3'd1;
      end
    end
    if (cmd_i.next_chunk) begin
      acc_d  = '0;
      kcnt_d = chunk_len;
      rem_d  = rem_next;
      nodd_d = !nodd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q <= sidx_d;
    bpos_q <= bpos_d;
    rem_q  <= rem_d;
    kcnt_q <= kcnt_d;
    nodd_q <= nodd_d;
    acc_q  <= acc_d;
    ack_q  <= ack_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[len_q[AW-1:0]] <= dearm;
    rdata_q <= mem_q[sidx_d[AW-1:0]];
  end

  assign sb_idx  = 5'(cnt_q - 9'd1);
  assign sm_mask = (32'd1 << sb_idx) - 32'd1;
  assign sm_mag  = acc_q[31:0] & sm_mask;
  assign sm_ok   = (cnt_q >= 9'd2) && (cnt_q <= 9'd32);
  assign smag    = !sm_ok ? 32'd0 : (acc_q[sb_idx] ? (32'd0 - sm_mag) : sm_mag);

  always_comb begin
    if (fmt_q == apfe_pkg::FMT_TEXT) begin
      text_conv = (acc_q[5:0] <= 6'd31) ? (7'(acc_q[5:0]) + 7'd64) : 7'(acc_q[5:0]);
    end else begin
      text_conv = (acc_q[3:0] < 4'd10) ? (7'd48 + 7'(acc_q[3:0]))
                                       : (7'd55 + 7'(acc_q[3:0]));
    end
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.out_sel)
      apfe_pkg::OUT_ACK: begin
        out_d.last_flag = 1'b1;
        out_d.status    = ack_q;
      end
      apfe_pkg::OUT_VALUE: begin
        out_d.field_value  = acc_q;
        out_d.signed_value = (fmt_q == apfe_pkg::FMT_SIGNMAG) ? signed'(smag) : 32'sd0;
        out_d.text_char    = chunked ? text_conv : 7'd0;
        out_d.last_flag    = chunked ? (!more && !pad) : 1'b1;
        out_d.status       = apfe_pkg::STAT_OK;
      end
      apfe_pkg::OUT_PAD: begin
        out_d.text_char = 7'd48;
        out_d.last_flag = 1'b1;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_sel != apfe_pkg::OUT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_sel != apfe_pkg::OUT_NONE) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.req      = req_q;
  assign stat_o.beyond   = (32'(sym_q) >= 32'(len_q));
  assign stat_o.empty    = chunked && (cnt_q == 9'd0);
  assign stat_o.chunked  = chunked;
  assign stat_o.stop     = chunked ? ((kcnt_q == 3'd0) || !bit_ok)
                                   : ((rem_q == 9'd0) || !bit_ok);
  assign stat_o.more     = more;
  assign stat_o.pad      = pad;
  assign stat_o.out_free = out_free;

endmodule

`default_nettype wire

[hdl/ais_payload_field_extractor.sv]
// Top level of the AIS payload de-armoring and field extraction block.
// A clear or append request gives a single result beat. An extract walks
// the payload one bit per clock while shifting, out of a memory with a
// registered read port; text or hex output is cut into chunks (six-bit
// chunks for text, four-bit chunks for hex), each sent as its own result
// beat, and hex output with an odd digit count adds a beat for the pad
// digit. A stalled output holds the extract between chunks. A result beat
// may wait in the output register while the next request is accepted.
// The payload memory has no reset; only entries below the current payload
// length are used in a result.
`default_nettype none
`include "assert_macros.svh"

module ais_payload_field_extractor #(
  parameter int MAX_CHARS      = 128,
  parameter int MAX_FIELD_BITS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apfe_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apfe_pkg::out_beat_t out_data_o
);

  apfe_pkg::cmd_t  ctrl_cmd;
  apfe_pkg::stat_t dp_stat;

  apfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  apfe_dpath #(
    .MAX_CHARS      (MAX_CHARS),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, ctrl_cmd.out_sel != apfe_pkg::OUT_NONE, dp_stat.out_free, "result beat loaded over a waiting beat")
  `ASSERT_IMPL(a_shift_not_stopped, clk_i, rst_ni, ctrl_cmd.shift, !dp_stat.stop, "bit shifted after the field end")
  `ASSERT_IMPL(a_idle_no_shift, clk_i, rst_ni, in_ready_o, !ctrl_cmd.shift && !ctrl_cmd.next_chunk, "datapath busy while ready")
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o && ctrl_cmd.decode, "request not decoded after accept")

endmodule

`default_nettype wire
